// ===== rtl/thread_ready_queue_manager_macros.svh =====
// ----------------------------------------------------------------------------
// thread_ready_queue_manager_macros
// Assertion macros for the thread ready-queue manager, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREAD_READY_QUEUE_MANAGER_MACROS_SVH
`define THREAD_READY_QUEUE_MANAGER_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define TRQM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define TRQM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/trqm_pkg.sv =====
// ----------------------------------------------------------------------------
// trqm_pkg
// Shared types and constants of the thread ready-queue manager.
// ----------------------------------------------------------------------------
package trqm_pkg;

    localparam int PRIORITY_LEVELS_DEF = 16;
    localparam int THREAD_SLOTS_DEF    = 32;

    localparam logic [3:0] CMD_INIT      = 4'd0;
    localparam logic [3:0] CMD_START     = 4'd1;
    localparam logic [3:0] CMD_READY     = 4'd2;
    localparam logic [3:0] CMD_RESUME    = 4'd3;
    localparam logic [3:0] CMD_WAKEUP    = 4'd4;
    localparam logic [3:0] CMD_SLEEP     = 4'd5;
    localparam logic [3:0] CMD_SLEEP_IPC = 4'd6;
    localparam logic [3:0] CMD_TERMINATE = 4'd7;
    localparam logic [3:0] CMD_SET_PRIO  = 4'd8;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_SUSP  = 2'd2;
    localparam logic [1:0] ST_TERM  = 2'd3;

    // One decoded command as it travels from the front end to the back end.
    typedef struct packed {
        logic [3:0]  command;
        logic [4:0]  thread_id;
        logic [3:0]  new_priority;
        logic        timer_start;
        logic [31:0] delay_ticks;
        logic        run_match;
    } trqm_cmd_t;

    // Result fields handed to the output register.
    typedef struct packed {
        logic        result_code;
        logic        schedule_request;
        logic        timer_start;
        logic [31:0] timer_delay;
        logic [15:0] ready_mask;
    } trqm_res_t;

endpackage

// ===== rtl/trqm_front.sv =====
// ----------------------------------------------------------------------------
// trqm_front
// Accepts commands, compares the sleep delay with the forever value and
// pushes decoded commands into a two-entry queue.
// ----------------------------------------------------------------------------
module trqm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [49:0]          s_tdata,
    output logic                 q_valid,
    input  logic                 q_pop,
    output trqm_pkg::trqm_cmd_t  q_cmd
);

    logic [31:0]         forever_reg;
    trqm_pkg::trqm_cmd_t fifo_reg [2];
    logic                rd_ptr_reg, wr_ptr_reg;
    logic [1:0]          count_reg;
    trqm_pkg::trqm_cmd_t in_cmd;
    logic                push;

    always_comb
    begin
        in_cmd.command      = s_tdata[3:0];
        in_cmd.thread_id    = s_tdata[8:4];
        in_cmd.new_priority = s_tdata[12:9];
        in_cmd.delay_ticks  = s_tdata[44:13];
        in_cmd.run_match    = (s_tdata[49:45] == s_tdata[8:4]) ? 1'b1 : 1'b0;
        in_cmd.timer_start  = (s_tdata[44:13] != forever_reg);
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forever_reg <= 32'hFFFF_FFFF;
            rd_ptr_reg  <= 1'b0;
            wr_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                forever_reg <= cfg_wr_data;
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/trqm_back.sv =====
// ----------------------------------------------------------------------------
// trqm_back
// Carries out one command at a time on the status, priority and link tables
// with a short sequencer, and holds the result in an output register.
// ----------------------------------------------------------------------------
module trqm_back
#(
    parameter int PRIORITY_LEVELS = trqm_pkg::PRIORITY_LEVELS_DEF,
    parameter int THREAD_SLOTS    = trqm_pkg::THREAD_SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  trqm_pkg::trqm_cmd_t  q_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output trqm_pkg::trqm_res_t  m_res
);

    localparam int TW = $clog2(THREAD_SLOTS);
    localparam int LW = TW + 1;
    localparam int PW = $clog2(PRIORITY_LEVELS);
    localparam logic [LW-1:0] NIL = LW'(THREAD_SLOTS);

    typedef enum logic [2:0] {S_IDLE, S_REMOVE, S_APPEND, S_REQUEUE, S_DONE} state_t;

    state_t                state_reg;
    trqm_pkg::trqm_cmd_t   cmd_reg;
    logic [1:0]            status_reg [THREAD_SLOTS];
    logic [PW-1:0]         prio_reg   [THREAD_SLOTS];
    logic [LW-1:0]         next_reg   [THREAD_SLOTS];
    logic [LW-1:0]         prev_reg   [THREAD_SLOTS];
    logic [LW-1:0]         head_reg   [PRIORITY_LEVELS];
    logic [LW-1:0]         tail_reg   [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] bitmap_reg;
    logic [LW-1:0]         thead_reg, ttail_reg;
    logic                  err_reg, sched_reg, tstart_reg;
    logic                  out_valid_reg;
    trqm_pkg::trqm_res_t   res_reg;

    logic [TW-1:0]         t;
    logic [1:0]            st;
    logic [PW-1:0]         np;
    logic                  tid_ok;
    logic                  to_term;
    logic [PW-1:0]         cur_p;
    logic [LW-1:0]         rp, rn, lt;

    assign t      = TW'(cmd_reg.thread_id);
    assign tid_ok = ({27'd0, cmd_reg.thread_id} < 32'(THREAD_SLOTS));
    assign st     = status_reg[t];
    assign np     = ({28'd0, cmd_reg.new_priority} >= 32'(PRIORITY_LEVELS)) ?
                    PW'(PRIORITY_LEVELS - 1) : PW'(cmd_reg.new_priority);
    assign cur_p  = prio_reg[t];
    assign rp     = prev_reg[t];
    assign rn     = next_reg[t];
    assign to_term = (cmd_reg.command == trqm_pkg::CMD_TERMINATE);
    assign lt     = to_term ? ttail_reg : tail_reg[cur_p];

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            bitmap_reg    <= '0;
            thead_reg     <= NIL;
            ttail_reg     <= NIL;
            err_reg       <= 1'b0;
            sched_reg     <= 1'b0;
            tstart_reg    <= 1'b0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                status_reg[i] <= trqm_pkg::ST_INIT;
                prio_reg[i]   <= '0;
                next_reg[i]   <= NIL;
                prev_reg[i]   <= NIL;
            end
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        state_reg <= S_REMOVE;
                    end
                end
                S_REMOVE:
                begin
                    // Decide the command and unlink the thread where needed.
                    err_reg    <= 1'b0;
                    sched_reg  <= 1'b0;
                    tstart_reg <= 1'b0;
                    state_reg  <= S_DONE;
                    if (!tid_ok)
                    begin
                        err_reg <= 1'b1;
                    end
                    else
                    begin
                        case (cmd_reg.command)
                            trqm_pkg::CMD_INIT:
                            begin
                                if (st == trqm_pkg::ST_READY || st == trqm_pkg::ST_TERM)
                                begin
                                    if (rp != NIL) next_reg[rp[TW-1:0]] <= rn;
                                    else if (st == trqm_pkg::ST_READY) head_reg[cur_p] <= rn;
                                    else thead_reg <= rn;
                                    if (rn != NIL) prev_reg[rn[TW-1:0]] <= rp;
                                    else if (st == trqm_pkg::ST_READY) tail_reg[cur_p] <= rp;
                                    else ttail_reg <= rp;
                                    if (st == trqm_pkg::ST_READY && rp == NIL && rn == NIL)
                                        bitmap_reg[cur_p] <= 1'b0;
                                    next_reg[t] <= NIL;
                                    prev_reg[t] <= NIL;
                                end
                                status_reg[t] <= trqm_pkg::ST_INIT;
                                prio_reg[t]   <= np;
                            end
                            trqm_pkg::CMD_START:
                            begin
                                if (st == trqm_pkg::ST_INIT)
                                begin
                                    sched_reg <= 1'b1;
                                    state_reg <= S_APPEND;
                                end
                            end
                            trqm_pkg::CMD_READY, trqm_pkg::CMD_RESUME,
                            trqm_pkg::CMD_WAKEUP:
                            begin
                                if (st == trqm_pkg::ST_TERM)
                                    err_reg <= 1'b1;
                                else if (st != trqm_pkg::ST_READY)
                                begin
                                    sched_reg <= (cmd_reg.command == trqm_pkg::CMD_RESUME);
                                    state_reg <= S_APPEND;
                                end
                            end
                            trqm_pkg::CMD_SLEEP, trqm_pkg::CMD_SLEEP_IPC,
                            trqm_pkg::CMD_TERMINATE, trqm_pkg::CMD_SET_PRIO:
                            begin
                                if (cmd_reg.command != trqm_pkg::CMD_SET_PRIO &&
                                    st == trqm_pkg::ST_TERM)
                                    err_reg <= 1'b1;
                                else if (cmd_reg.command != trqm_pkg::CMD_TERMINATE &&
                                         cmd_reg.command != trqm_pkg::CMD_SET_PRIO &&
                                         st == trqm_pkg::ST_SUSP)
                                begin
                                end
                                else
                                begin
                                    if (st == trqm_pkg::ST_READY)
                                    begin
                                        if (rp != NIL) next_reg[rp[TW-1:0]] <= rn;
                                        else head_reg[cur_p] <= rn;
                                        if (rn != NIL) prev_reg[rn[TW-1:0]] <= rp;
                                        else tail_reg[cur_p] <= rp;
                                        if (rp == NIL && rn == NIL)
                                            bitmap_reg[cur_p] <= 1'b0;
                                        next_reg[t] <= NIL;
                                        prev_reg[t] <= NIL;
                                    end
                                    if (cmd_reg.command == trqm_pkg::CMD_SET_PRIO)
                                    begin
                                        prio_reg[t] <= np;
                                        if (st == trqm_pkg::ST_READY)
                                            state_reg <= S_REQUEUE;
                                    end
                                    else if (to_term)
                                    begin
                                        sched_reg <= cmd_reg.run_match;
                                        state_reg <= S_APPEND;
                                    end
                                    else
                                    begin
                                        tstart_reg    <= cmd_reg.timer_start;
                                        sched_reg     <= 1'b1;
                                        status_reg[t] <= trqm_pkg::ST_SUSP;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_REQUEUE, S_APPEND:
                begin
                    // Join the tail of the ready queue or the terminate list.
                    next_reg[t] <= NIL;
                    prev_reg[t] <= lt;
                    if (lt != NIL) next_reg[lt[TW-1:0]] <= {1'b0, t};
                    else if (to_term) thead_reg <= {1'b0, t};
                    else head_reg[cur_p] <= {1'b0, t};
                    if (to_term)
                    begin
                        ttail_reg     <= {1'b0, t};
                        status_reg[t] <= trqm_pkg::ST_TERM;
                    end
                    else
                    begin
                        tail_reg[cur_p]   <= {1'b0, t};
                        bitmap_reg[cur_p] <= 1'b1;
                        status_reg[t]     <= trqm_pkg::ST_READY;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        res_reg.result_code      <= err_reg;
                        res_reg.schedule_request <= sched_reg;
                        res_reg.timer_start      <= tstart_reg;
                        res_reg.timer_delay      <= tstart_reg ? cmd_reg.delay_ticks : 32'd0;
                        res_reg.ready_mask       <= 16'(bitmap_reg);
                        out_valid_reg            <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/thread_ready_queue_manager.sv =====
// ----------------------------------------------------------------------------
// thread_ready_queue_manager: thread commands on priority ready queues.
// A command passes the two-entry queue, then the states remove and done; append or
// requeue comes between when the thread joins a list. The sequencer takes one command at a time.
// Reset: asynchronous; lists empty, threads in init at priority 0, forever all ones.
// ----------------------------------------------------------------------------
`include "thread_ready_queue_manager_macros.svh"

module thread_ready_queue_manager
#(
    parameter int PRIORITY_LEVELS = trqm_pkg::PRIORITY_LEVELS_DEF,
    parameter int THREAD_SLOTS    = trqm_pkg::THREAD_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: forever_delay register.
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[3:0], thread_id[8:4], new_priority[12:9], delay_ticks[44:13],
    // running_thread[49:45], zero fill to 56 bits.
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_code[0], schedule_request[1], timer_start[2], timer_delay[34:3],
    // ready_mask[50:35], zero fill to 56 bits.
    output logic [55:0] m_tdata
);

    // The front end takes every transfer into a two-entry queue, so
    // it never waits on the back end unless both entries are full.
    logic                q_valid, q_pop;
    trqm_pkg::trqm_cmd_t q_cmd;
    trqm_pkg::trqm_res_t res;

    // The front end sees the command fields without the zero fill.
    trqm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata[49:0]),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd)
    );

    trqm_back #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .THREAD_SLOTS    (THREAD_SLOTS)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {5'd0, res.ready_mask, res.timer_delay, res.timer_start,
                      res.schedule_request, res.result_code};

    // A result that does not start a timer carries a zero delay.
    `TRQM_ASSERT_IMPLY(a_dly_zero, m_tvalid && !res.timer_start, res.timer_delay == '0, "stray delay")
    // A timer is never started together with an error.
    `TRQM_ASSERT_IMPLY(a_timer_ok, m_tvalid && res.timer_start, !res.result_code, "timer on error")
    // A stalled result holds its data.
    `TRQM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "unstable result")

endmodule
